FILE: src/apm_pkg.sv
// Autoranging power meter: shared widths, register map, reset values and the
// configuration struct. No dependencies.
package apm_pkg;

  // Input count width
  localparam int COUNT_BITS = 10;

  // Fixed field widths
  localparam int RANGE_W    = 10;
  localparam int PRESS_W    = 13;
  localparam int SCALE_W    = 24;
  localparam int VOLT_MV_W  = 13;
  localparam int AMP_MA_W   = 14;
  localparam int POWER_MW_W = 17;
  localparam int FRAC_W     = 16;

  // Derived datapath widths
  localparam int Q_W       = COUNT_BITS + SCALE_W;            // v_q16 / a_q16
  localparam int HI_W      = Q_W - FRAC_W;                    // integer part
  localparam int CMP_W     = (COUNT_BITS > RANGE_W) ? COUNT_BITS : RANGE_W;
  localparam int MUL_A_W   = Q_W;
  localparam int MUL_B_W   = (COUNT_BITS > VOLT_MV_W) ? COUNT_BITS : VOLT_MV_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIVD_W    = PROD_W - FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int MW_DIVISOR = 1000;
  localparam int REM_W     = $clog2(MW_DIVISOR);

  // Output limits
  localparam logic [VOLT_MV_W-1:0]  MV_MAX = '1;
  localparam logic [AMP_MA_W-1:0]   MA_MAX = '1;
  localparam logic [POWER_MW_W-1:0] MW_MAX = '1;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam int PADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_RANGE_UP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_DOWN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PRESS_LVL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VOLT_SCALE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AMP_GAIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_AMP_PLAIN  = 3'd5;

  // Reset values
  localparam logic [RANGE_W-1:0] RST_RANGE_UP   = 10'd1000;
  localparam logic [RANGE_W-1:0] RST_RANGE_DOWN = 10'd40;
  localparam logic [PRESS_W-1:0] RST_PRESS_LVL  = 13'd2000;
  localparam logic [SCALE_W-1:0] RST_VOLT_SCALE = 24'd390400;
  localparam logic [SCALE_W-1:0] RST_AMP_GAIN   = 24'd35200;
  localparam logic [SCALE_W-1:0] RST_AMP_PLAIN  = 24'd704000;

  typedef struct packed {
    logic [RANGE_W-1:0] range_up_count;
    logic [RANGE_W-1:0] range_down_count;
    logic [PRESS_W-1:0] press_level_mv;
    logic [SCALE_W-1:0] volt_scale_q16;
    logic [SCALE_W-1:0] amp_scale_gain_q16;
    logic [SCALE_W-1:0] amp_scale_plain_q16;
  } cfg_t;

endpackage

FILE: src/apm_if.sv
// Valid/ready channel interfaces for the measurement input and the result.
// Depends on apm_pkg.
interface apm_in_if;
  logic                           valid;
  logic                           ready;
  logic [apm_pkg::COUNT_BITS-1:0] volt_count;
  logic [apm_pkg::COUNT_BITS-1:0] amp_count;

  modport source (output valid, volt_count, amp_count, input ready);
  modport sink (input valid, volt_count, amp_count, output ready);
endinterface

interface apm_out_if;
  logic                           valid;
  logic                           ready;
  logic [apm_pkg::VOLT_MV_W-1:0]  volt_mv;
  logic [apm_pkg::AMP_MA_W-1:0]   amp_ma;
  logic [apm_pkg::POWER_MW_W-1:0] power_mw;
  logic                           gain_used;
  logic                           gain_next;
  logic                           press_event;

  modport source (output valid, volt_mv, amp_ma, power_mw, gain_used, gain_next,
                  press_event, input ready);
  modport sink (input valid, volt_mv, amp_ma, power_mw, gain_used, gain_next,
                press_event, output ready);
endinterface

FILE: src/apm_regs.sv
// APB configuration registers of the power meter.
// Depends on apm_pkg.
module apm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apm_pkg::PADDR_W-1:0]   paddr,
  input  logic [apm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [apm_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready,
  output apm_pkg::cfg_t                 cfg_o
);

  apm_pkg::cfg_t                   cfg_q;
  logic [apm_pkg::REG_IDX_W-1:0]   idx;
  logic                            wr_en;

  assign idx    = paddr[apm_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_up_count      <= apm_pkg::RST_RANGE_UP;
      cfg_q.range_down_count    <= apm_pkg::RST_RANGE_DOWN;
      cfg_q.press_level_mv      <= apm_pkg::RST_PRESS_LVL;
      cfg_q.volt_scale_q16      <= apm_pkg::RST_VOLT_SCALE;
      cfg_q.amp_scale_gain_q16  <= apm_pkg::RST_AMP_GAIN;
      cfg_q.amp_scale_plain_q16 <= apm_pkg::RST_AMP_PLAIN;
    end else if (wr_en) begin
      unique case (idx)
        apm_pkg::REG_RANGE_UP:
          cfg_q.range_up_count <= pwdata[apm_pkg::RANGE_W-1:0];
        apm_pkg::REG_RANGE_DOWN:
          cfg_q.range_down_count <= pwdata[apm_pkg::RANGE_W-1:0];
        apm_pkg::REG_PRESS_LVL:
          cfg_q.press_level_mv <= pwdata[apm_pkg::PRESS_W-1:0];
        apm_pkg::REG_VOLT_SCALE:
          cfg_q.volt_scale_q16 <= pwdata[apm_pkg::SCALE_W-1:0];
        apm_pkg::REG_AMP_GAIN:
          cfg_q.amp_scale_gain_q16 <= pwdata[apm_pkg::SCALE_W-1:0];
        apm_pkg::REG_AMP_PLAIN:
          cfg_q.amp_scale_plain_q16 <= pwdata[apm_pkg::SCALE_W-1:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      apm_pkg::REG_RANGE_UP:
        prdata = apm_pkg::APB_DATA_W'(cfg_q.range_up_count);
      apm_pkg::REG_RANGE_DOWN:
        prdata = apm_pkg::APB_DATA_W'(cfg_q.range_down_count);
      apm_pkg::REG_PRESS_LVL:
        prdata = apm_pkg::APB_DATA_W'(cfg_q.press_level_mv);
      apm_pkg::REG_VOLT_SCALE:
        prdata = apm_pkg::APB_DATA_W'(cfg_q.volt_scale_q16);
      apm_pkg::REG_AMP_GAIN:
        prdata = apm_pkg::APB_DATA_W'(cfg_q.amp_scale_gain_q16);
      apm_pkg::REG_AMP_PLAIN:
        prdata = apm_pkg::APB_DATA_W'(cfg_q.amp_scale_plain_q16);
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: src/apm_mul.sv
// Bit-serial shift-add multiplier, multiplier bits taken MSB first.
// Depends on apm_pkg.
module apm_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [apm_pkg::MUL_A_W-1:0]   mcand_i,
  input  logic [apm_pkg::MUL_B_W-1:0]   mplr_i,
  output logic                          done_o,
  output logic [apm_pkg::PROD_W-1:0]    prod_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [apm_pkg::MUL_CNT_W-1:0]   cnt_q;
  logic [apm_pkg::MUL_A_W-1:0]     mcand_q;
  logic [apm_pkg::MUL_B_W-1:0]     mplr_q;
  logic [apm_pkg::PROD_W-1:0]      acc_q;
  logic [apm_pkg::PROD_W-1:0]      addend;

  assign addend = mplr_q[apm_pkg::MUL_B_W-1] ? apm_pkg::PROD_W'(mcand_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == apm_pkg::MUL_CNT_W'(apm_pkg::MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      mplr_q  <= mplr_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      acc_q  <= {acc_q[apm_pkg::PROD_W-2:0], 1'b0} + addend;
      mplr_q <= {mplr_q[apm_pkg::MUL_B_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: src/apm_div.sv
// Restoring divider by the constant 1000, one quotient bit per cycle.
// Depends on apm_pkg.
module apm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [apm_pkg::DIVD_W-1:0]   dividend_i,
  output logic                         done_o,
  output logic [apm_pkg::DIVD_W-1:0]   quo_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [apm_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [apm_pkg::DIVD_W-1:0]      work_q;   // dividend out at top, quotient in at bottom
  logic [apm_pkg::REM_W-1:0]       rem_q;
  logic [apm_pkg::REM_W:0]         trial;
  logic [apm_pkg::REM_W:0]         diff;
  logic                            fits;

  assign trial = {rem_q, work_q[apm_pkg::DIVD_W-1]};
  assign fits  = trial >= (apm_pkg::REM_W + 1)'(apm_pkg::MW_DIVISOR);
  assign diff  = trial - (apm_pkg::REM_W + 1)'(apm_pkg::MW_DIVISOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == apm_pkg::DIV_CNT_W'(apm_pkg::DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= {work_q[apm_pkg::DIVD_W-2:0], fits};
      rem_q  <= fits ? diff[apm_pkg::REM_W-1:0] : trial[apm_pkg::REM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = work_q;

endmodule

FILE: src/autoranging_power_meter.sv
// Autoranging power meter top level: sequencer, range/press state, result register.
// Depends on apm_pkg, apm_if, apm_regs, apm_mul, apm_div.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in_i    | in  | valid/ready        | volt_count, amp_count
//  out_o   | out | valid/ready        | volt_mv, amp_ma, power_mw, gain_used,
//          |     |                    | gain_next, press_event
//  apb     | in  | psel/penable/pready| paddr, pwdata -> prdata (regs at 4*i)
//
//  One transaction at a time: two 13-step shift-add passes (counts x scales,
//  then mV x Q16 current) and a 31-step division by 1000, each pass handed
//  on to the next. The shift-add multiplier and the serial divider take up
//  most of the time.
//  Reset (rst_ni, async low) restores the register defaults, gain mode on and
//  the button released; no clearing pass.
//  A finished result waits in the output register; the next input transaction
//  is taken meanwhile, and a result only stalls the sequencer if the previous
//  one has still not been taken.
module autoranging_power_meter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  apm_in_if.sink                         in_i,
  apm_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [apm_pkg::PADDR_W-1:0]    paddr,
  input  logic [apm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [apm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;  // v_q16 and a_q16 in parallel
  localparam logic [2:0] ST_MUL2 = 3'd2;  // mV x a_q16
  localparam logic [2:0] ST_DIV  = 3'd3;  // /1000
  localparam logic [2:0] ST_DONE = 3'd4;  // waiting for the output register

  apm_pkg::cfg_t cfg;

  logic [2:0] state_q, state_d;

  // Per-transaction context
  logic [apm_pkg::COUNT_BITS-1:0] ac_q;
  logic                           used_q;
  logic [apm_pkg::VOLT_MV_W-1:0]  mv_q;
  logic [apm_pkg::AMP_MA_W-1:0]   ma_q;
  logic [apm_pkg::POWER_MW_W-1:0] mw_q;
  logic                           press_q;

  // Persistent state
  logic gain_q;
  logic held_q;

  // Output register
  logic                           out_valid_q;
  logic [apm_pkg::VOLT_MV_W-1:0]  out_mv_q;
  logic [apm_pkg::AMP_MA_W-1:0]   out_ma_q;
  logic [apm_pkg::POWER_MW_W-1:0] out_mw_q;
  logic                           out_used_q;
  logic                           out_next_q;
  logic                           out_press_q;

  // Units
  logic                           mulv_start, mulv_done;
  logic [apm_pkg::MUL_A_W-1:0]    mulv_mcand;
  logic [apm_pkg::MUL_B_W-1:0]    mulv_mplr;
  logic [apm_pkg::PROD_W-1:0]     mulv_prod;
  logic                           mula_done;
  logic [apm_pkg::MUL_A_W-1:0]    mula_mcand;
  logic [apm_pkg::PROD_W-1:0]     mula_prod;
  logic                           div_start, div_done;
  logic [apm_pkg::DIVD_W-1:0]     div_quo;

  logic                           in_acc;
  logic                           out_acc;
  logic                           out_load;

  // MUL1 results
  logic [apm_pkg::Q_W-1:0]        v_q16;
  logic [apm_pkg::Q_W-1:0]        a_q16;
  logic [apm_pkg::HI_W-1:0]       v_hi;
  logic [apm_pkg::HI_W-1:0]       a_hi;
  logic [apm_pkg::HI_W-1:0]       press_hi;
  logic [apm_pkg::VOLT_MV_W-1:0]  mv_d;
  logic [apm_pkg::AMP_MA_W-1:0]   ma_d;
  logic                           v_below, v_above;
  logic                           go_plain, go_gain;
  logic                           mul1_fin;

  assign in_acc   = in_i.valid & in_i.ready;
  assign out_acc  = out_o.valid & out_o.ready;
  assign out_load = (state_q == ST_DONE) & (~out_valid_q | out_o.ready);
  // both units start together and finish in the same cycle
  assign mul1_fin = (state_q == ST_MUL1) & mulv_done & mula_done;

  assign in_i.ready = (state_q == ST_IDLE);

  apm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Voltage unit is reused for the power product once v_q16 is out.
  assign mulv_start = in_acc | mul1_fin;
  assign mulv_mcand = (state_q == ST_IDLE) ? apm_pkg::MUL_A_W'(cfg.volt_scale_q16) : a_q16;
  assign mulv_mplr  = (state_q == ST_IDLE) ? apm_pkg::MUL_B_W'(in_i.volt_count)
                                           : apm_pkg::MUL_B_W'(mv_d);

  apm_mul u_mul_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mulv_start),
    .mcand_i (mulv_mcand),
    .mplr_i  (mulv_mplr),
    .done_o  (mulv_done),
    .prod_o  (mulv_prod)
  );

  // Current factor picked by the mode announced on the previous result
  assign mula_mcand = gain_q ? apm_pkg::MUL_A_W'(cfg.amp_scale_gain_q16)
                             : apm_pkg::MUL_A_W'(cfg.amp_scale_plain_q16);

  apm_mul u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .mcand_i (mula_mcand),
    .mplr_i  (apm_pkg::MUL_B_W'(in_i.amp_count)),
    .done_o  (mula_done),
    .prod_o  (mula_prod)
  );

  assign div_start = (state_q == ST_MUL2) & mulv_done;

  apm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mulv_prod[apm_pkg::PROD_W-1:apm_pkg::FRAC_W]),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Scaling, saturation and thresholds once both counts are multiplied
  assign v_q16    = mulv_prod[apm_pkg::Q_W-1:0];
  assign a_q16    = mula_prod[apm_pkg::Q_W-1:0];
  assign v_hi     = v_q16[apm_pkg::Q_W-1:apm_pkg::FRAC_W];
  assign a_hi     = a_q16[apm_pkg::Q_W-1:apm_pkg::FRAC_W];
  assign press_hi = apm_pkg::HI_W'(cfg.press_level_mv);

  assign mv_d = (v_hi > apm_pkg::HI_W'(apm_pkg::MV_MAX)) ? apm_pkg::MV_MAX
              : v_hi[apm_pkg::VOLT_MV_W-1:0];
  assign ma_d = (a_hi > apm_pkg::HI_W'(apm_pkg::MA_MAX)) ? apm_pkg::MA_MAX
              : a_hi[apm_pkg::AMP_MA_W-1:0];

  // Press compare at full Q16 precision: below, or strictly above
  assign v_below = v_hi < press_hi;
  assign v_above = (v_hi > press_hi) |
                   ((v_hi == press_hi) & (|v_q16[apm_pkg::FRAC_W-1:0]));

  // Range hysteresis
  assign go_plain = used_q  & (apm_pkg::CMP_W'(ac_q) > apm_pkg::CMP_W'(cfg.range_up_count));
  assign go_gain  = ~used_q & (apm_pkg::CMP_W'(ac_q) <= apm_pkg::CMP_W'(cfg.range_down_count));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc)    state_d = ST_MUL1;
      ST_MUL1: if (mul1_fin)  state_d = ST_MUL2;
      ST_MUL2: if (mulv_done) state_d = ST_DIV;
      ST_DIV:  if (div_done)  state_d = ST_DONE;
      ST_DONE: if (out_load)  state_d = ST_IDLE;
      default:                state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= 1'b1;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul1_fin) begin
        if (go_plain) begin
          gain_q <= 1'b0;
        end else if (go_gain) begin
          gain_q <= 1'b1;
        end
        if (v_below & ~held_q) begin
          held_q <= 1'b1;
        end else if (v_above & held_q) begin
          held_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ac_q   <= in_i.amp_count;
      used_q <= gain_q;
    end
    if (mul1_fin) begin
      mv_q    <= mv_d;
      ma_q    <= ma_d;
      press_q <= v_below & ~held_q;
    end
    if ((state_q == ST_DIV) & div_done) begin
      mw_q <= (div_quo > apm_pkg::DIVD_W'(apm_pkg::MW_MAX)) ? apm_pkg::MW_MAX
            : div_quo[apm_pkg::POWER_MW_W-1:0];
    end
    if (out_load) begin
      out_mv_q    <= mv_q;
      out_ma_q    <= ma_q;
      out_mw_q    <= mw_q;
      out_used_q  <= used_q;
      out_next_q  <= gain_q;
      out_press_q <= press_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.volt_mv     = out_mv_q;
  assign out_o.amp_ma      = out_ma_q;
  assign out_o.power_mw    = out_mw_q;
  assign out_o.gain_used   = out_used_q;
  assign out_o.gain_next   = out_next_q;
  assign out_o.press_event = out_press_q;

endmodule

FILE: src/apm_chk.sv
// Port-level checker for the power meter and its bind to the top level.
// Depends on apm_pkg and autoranging_power_meter.
module apm_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [apm_pkg::VOLT_MV_W-1:0]  volt_mv_i,
  input logic [apm_pkg::AMP_MA_W-1:0]   amp_ma_i,
  input logic [apm_pkg::POWER_MW_W-1:0] power_mw_i,
  input logic                           gain_used_i,
  input logic                           gain_next_i,
  input logic                           press_event_i
);

  // One transaction in flight: no back-to-back input acceptance
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while a transaction is in flight");

  // Zero volts gives zero power
  a_zero_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (volt_mv_i == '0)) |-> (power_mw_i == '0))
    else $error("power reported with zero voltage");

  // Stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn under stall");

  // Stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(volt_mv_i) && $stable(amp_ma_i) && $stable(power_mw_i) &&
       $stable(gain_used_i) && $stable(gain_next_i) && $stable(press_event_i)))
    else $error("result payload changed under stall");

endmodule

bind autoranging_power_meter apm_chk u_apm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .volt_mv_i     (out_o.volt_mv),
  .amp_ma_i      (out_o.amp_ma),
  .power_mw_i    (out_o.power_mw),
  .gain_used_i   (out_o.gain_used),
  .gain_next_i   (out_o.gain_next),
  .press_event_i (out_o.press_event)
);

FILE: tb/tb_autoranging_power_meter.sv
// Self-checking testbench for the autoranging power meter: directed stimulus table,
// then randomised measurement phases under varied register settings.
// Depends on apm_pkg, apm_if and the autoranging_power_meter RTL.
module tb_autoranging_power_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import apm_pkg::*;

  localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction of any kind
  localparam int SETTLE_CYCLES = 80;    // a little over one full measurement

  // Register slots past the map; writes there must leave everything alone
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [VOLT_MV_W-1:0]  volt_mv;
    logic [AMP_MA_W-1:0]   amp_ma;
    logic [POWER_MW_W-1:0] power_mw;
    logic                  gain_used;
    logic                  gain_next;
    logic                  press_event;
  } reading_t;

  // ROW_PINNED carries a hand-worked reading; ROW_ITEM relies on the predictor
  typedef enum logic [1:0] {ROW_ITEM, ROW_PINNED, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [APB_DATA_W-1:0] reg_value;
    logic [COUNT_BITS-1:0] volt_count;
    logic [COUNT_BITS-1:0] amp_count;
    reading_t              pinned;
  } row_t;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_COIN, SINK_SPARSE, SINK_PATTERN} sink_mode_e;

  logic clk_i;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  apm_in_if  meas_ch ();
  apm_out_if res_ch ();

  autoranging_power_meter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (meas_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the meter: register copy plus range and button state
  cfg_t     meter_cfg;
  logic     gain_mode_q;
  logic     button_held_q;

  reading_t pending_readings[$];  // one per accepted measurement, oldest first
  row_t     directed_rows[$];
  reading_t oldest_reading;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor. Q16 products are carried at 64 bits so nothing is lost before
  // the truncations; power takes the saturated mV but the full-precision
  // current. Range hysteresis and the press latch advance once per reading.
  // --------------------------------------------------------------------------
  function automatic reading_t predict_reading(input logic [COUNT_BITS-1:0] vc,
                                               input logic [COUNT_BITS-1:0] ac);
    reading_t    r;
    logic [63:0] v_q16;
    logic [63:0] a_q16;
    logic [63:0] mv;
    logic [63:0] ma;
    logic [63:0] mw;
    logic [63:0] thr;
    r.gain_used = gain_mode_q;
    v_q16 = 64'(vc) * 64'(meter_cfg.volt_scale_q16);
    a_q16 = 64'(ac) * 64'(gain_mode_q ? meter_cfg.amp_scale_gain_q16
                                       : meter_cfg.amp_scale_plain_q16);
    mv = v_q16 >> FRAC_W;
    if (mv > 64'(MV_MAX)) mv = 64'(MV_MAX);
    ma = a_q16 >> FRAC_W;
    if (ma > 64'(MA_MAX)) ma = 64'(MA_MAX);
    mw = (mv * a_q16) / (64'(MW_DIVISOR) << FRAC_W);
    if (mw > 64'(MW_MAX)) mw = 64'(MW_MAX);

    if (gain_mode_q && ac > meter_cfg.range_up_count) gain_mode_q = 1'b0;
    else if (!gain_mode_q && ac <= meter_cfg.range_down_count) gain_mode_q = 1'b1;

    // strict compare both ways: sitting exactly on the level holds the latch
    thr = 64'(meter_cfg.press_level_mv) << FRAC_W;
    r.press_event = 1'b0;
    if (v_q16 < thr && !button_held_q) begin
      button_held_q = 1'b1;
      r.press_event = 1'b1;
    end else if (v_q16 > thr && button_held_q) begin
      button_held_q = 1'b0;
    end

    r.volt_mv   = mv[VOLT_MV_W-1:0];
    r.amp_ma    = ma[AMP_MA_W-1:0];
    r.power_mw  = mw[POWER_MW_W-1:0];
    r.gain_next = gain_mode_q;
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] clamp_count(input longint aim);
    if (aim < 0) return '0;
    if (aim > COUNT_MAX) return COUNT_MAX[COUNT_BITS-1:0];
    return aim[COUNT_BITS-1:0];
  endfunction

  task automatic report_field(input string what, input longint unsigned want,
                              input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic void add_item(input logic [COUNT_BITS-1:0] vc,
                                   input logic [COUNT_BITS-1:0] ac);
    row_t row;
    row.kind       = ROW_ITEM;
    row.reg_idx    = '0;
    row.reg_value  = '0;
    row.volt_count = vc;
    row.amp_count  = ac;
    row.pinned     = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pinned(input logic [COUNT_BITS-1:0] vc,
                                     input logic [COUNT_BITS-1:0] ac,
                                     input int unsigned mv, input int unsigned ma,
                                     input int unsigned mw, input logic used,
                                     input logic next, input logic press);
    row_t row;
    row.kind       = ROW_PINNED;
    row.reg_idx    = '0;
    row.reg_value  = '0;
    row.volt_count = vc;
    row.amp_count  = ac;
    row.pinned     = '{volt_mv: mv[VOLT_MV_W-1:0], amp_ma: ma[AMP_MA_W-1:0],
                       power_mw: mw[POWER_MW_W-1:0], gain_used: used,
                       gain_next: next, press_event: press};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write(input logic [REG_IDX_W-1:0] idx,
                                    input logic [APB_DATA_W-1:0] value);
    row_t row;
    row.kind       = ROW_WRITE;
    row.reg_idx    = idx;
    row.reg_value  = value;
    row.volt_count = '0;
    row.amp_count  = '0;
    row.pinned     = '0;
    directed_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Bus tasks; all are entered just after a rising edge
  // --------------------------------------------------------------------------

  // Setup cycle, then access cycle until pready; the bus then idles, so the
  // next transfer never lands a second assignment on psel in the same step.
  task automatic apb_transfer(input logic is_write, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write, mirror into the shadow copy at register width, read back mapped registers
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    logic [APB_DATA_W-1:0] held;
    apb_transfer(1'b1, idx, value, rd);
    held = '0;
    case (idx)
      REG_RANGE_UP: begin
        meter_cfg.range_up_count = value[RANGE_W-1:0];
        held = APB_DATA_W'(meter_cfg.range_up_count);
      end
      REG_RANGE_DOWN: begin
        meter_cfg.range_down_count = value[RANGE_W-1:0];
        held = APB_DATA_W'(meter_cfg.range_down_count);
      end
      REG_PRESS_LVL: begin
        meter_cfg.press_level_mv = value[PRESS_W-1:0];
        held = APB_DATA_W'(meter_cfg.press_level_mv);
      end
      REG_VOLT_SCALE: begin
        meter_cfg.volt_scale_q16 = value[SCALE_W-1:0];
        held = APB_DATA_W'(meter_cfg.volt_scale_q16);
      end
      REG_AMP_GAIN: begin
        meter_cfg.amp_scale_gain_q16 = value[SCALE_W-1:0];
        held = APB_DATA_W'(meter_cfg.amp_scale_gain_q16);
      end
      REG_AMP_PLAIN: begin
        meter_cfg.amp_scale_plain_q16 = value[SCALE_W-1:0];
        held = APB_DATA_W'(meter_cfg.amp_scale_plain_q16);
      end
      default: ;
    endcase
    if (idx <= REG_AMP_PLAIN) begin
      apb_transfer(1'b0, idx, '0, rd);
      report_field("register readback", held, rd);
    end
  endtask

  // Offer one measurement and hold it until the meter takes it
  task automatic send_counts(input logic [COUNT_BITS-1:0] vc,
                             input logic [COUNT_BITS-1:0] ac);
    meas_ch.valid      <= 1'b1;
    meas_ch.volt_count <= vc;
    meas_ch.amp_count  <= ac;
    @(posedge clk_i);
    while (meas_ch.ready !== 1'b1) @(posedge clk_i);
  endtask

  // Stop offering and wait for every outstanding reading; each measurement
  // gives exactly one reading, so an empty store means the meter is idle
  task automatic drain_results();
    meas_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: ready follows runs of differing character - always ready,
  // coin toss, mostly stalled, or a short repeating mask.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned run;
    int unsigned k;
    logic [7:0]  pattern;
    res_ch.ready = 1'b0;
    forever begin
      mode    = sink_mode_e'($urandom_range(0, 3));
      run     = $urandom_range(16, 160);
      pattern = 8'($urandom_range(1, 255));
      for (k = 0; k < run; k++) begin
        @(posedge clk_i);
        case (mode)
          SINK_ALWAYS: res_ch.ready <= 1'b1;
          SINK_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     res_ch.ready <= pattern[k % 8];
        endcase
      end
    end
  end

  // Each accepted reading against the oldest prediction, field by field
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: reading with none expected, expected nothing, actual mV %0d mA %0d",
                 $time, res_ch.volt_mv, res_ch.amp_ma);
        mismatch_count++;
      end else begin
        oldest_reading = pending_readings.pop_front();
        report_field("volt_mv", oldest_reading.volt_mv, res_ch.volt_mv);
        report_field("amp_ma", oldest_reading.amp_ma, res_ch.amp_ma);
        report_field("power_mw", oldest_reading.power_mw, res_ch.power_mw);
        report_field("gain_used", oldest_reading.gain_used, res_ch.gain_used);
        report_field("gain_next", oldest_reading.gain_next, res_ch.gain_next);
        report_field("press_event", oldest_reading.press_event, res_ch.press_event);
      end
    end
  end

  // Watchdog: any transaction on any port restarts the count
  always @(posedge clk_i) begin
    if ((meas_ch.valid && meas_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    reading_t              predicted;
    logic [COUNT_BITS-1:0] vc;
    logic [COUNT_BITS-1:0] ac;
    longint                aim;
    int                    random_sent;
    int                    phase_left;
    int                    burst;
    int                    gap;
    int unsigned           flavour;
    logic [APB_DATA_W-1:0] up_w;
    logic [APB_DATA_W-1:0] down_w;
    logic [APB_DATA_W-1:0] press_w;
    logic [APB_DATA_W-1:0] vs_w;
    logic [APB_DATA_W-1:0] ag_w;
    logic [APB_DATA_W-1:0] ap_w;

    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    meas_ch.valid      = 1'b0;
    meas_ch.volt_count = '0;
    meas_ch.amp_count  = '0;

    meter_cfg = '{range_up_count: RST_RANGE_UP, range_down_count: RST_RANGE_DOWN,
                  press_level_mv: RST_PRESS_LVL, volt_scale_q16: RST_VOLT_SCALE,
                  amp_scale_gain_q16: RST_AMP_GAIN, amp_scale_plain_q16: RST_AMP_PLAIN};
    gain_mode_q   = 1'b1;
    button_held_q = 1'b0;

    // Reset defaults: a zero reading is a fresh press, and only the first
    add_pinned(0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1);
    add_pinned(0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0);
    // Full scale leaves gain; then walk the hysteresis edges both ways
    add_item(1023, 1023);
    add_item(500, 1023);
    add_item(500, 40);     // on the lower threshold: back to gain
    add_item(500, 1000);   // on the upper threshold: stays in gain
    add_item(500, 1001);
    add_item(500, 41);
    add_item(500, 0);
    // 1 mV per count puts the press level on an exact count
    add_write(REG_VOLT_SCALE, 32'd65536);
    add_write(REG_PRESS_LVL, 32'd500);
    add_pinned(499, 0, 499, 0, 0, 1'b1, 1'b1, 1'b1);
    add_pinned(500, 0, 500, 0, 0, 1'b1, 1'b1, 1'b0);  // on the level: still held
    add_pinned(499, 0, 499, 0, 0, 1'b1, 1'b1, 1'b0);  // held, no second event
    add_pinned(501, 0, 501, 0, 0, 1'b1, 1'b1, 1'b0);  // above: released
    add_pinned(500, 0, 500, 0, 0, 1'b1, 1'b1, 1'b0);  // on the level, released
    add_pinned(499, 0, 499, 0, 0, 1'b1, 1'b1, 1'b1);
    // Oversized writes are cut to register width; full-scale counts saturate every output
    add_write(REG_VOLT_SCALE, 32'hFFFF_FFFF);
    add_write(REG_AMP_GAIN, 32'h00FF_FFFF);
    add_write(REG_AMP_PLAIN, 32'hFFFF_FFFF);
    add_write(REG_RANGE_UP, 32'd0);
    add_write(REG_RANGE_DOWN, 32'hFFFF_FFFF);
    add_write(REG_PRESS_LVL, 32'hFFFF_FFFF);
    add_pinned(1023, 1023, 8191, 16383, 131071, 1'b1, 1'b0, 1'b0);
    add_pinned(1023, 1023, 8191, 16383, 131071, 1'b0, 1'b1, 1'b0);
    add_pinned(0, 1023, 0, 16383, 0, 1'b1, 1'b0, 1'b1);  // press still reports data
    add_item(1, 1);
    // All-zero scales and a zero press level: reading sits on the level
    add_write(REG_RANGE_UP, 32'd1023);
    add_write(REG_RANGE_DOWN, 32'd0);
    add_write(REG_PRESS_LVL, 32'd0);
    add_write(REG_VOLT_SCALE, 32'd0);
    add_write(REG_AMP_GAIN, 32'd0);
    add_write(REG_AMP_PLAIN, 32'd0);
    add_pinned(1023, 1023, 0, 0, 0, 1'b1, 1'b1, 1'b0);
    // Back to defaults, then poke the slots past the map
    add_write(REG_RANGE_UP, 32'(RST_RANGE_UP));
    add_write(REG_RANGE_DOWN, 32'(RST_RANGE_DOWN));
    add_write(REG_PRESS_LVL, 32'(RST_PRESS_LVL));
    add_write(REG_VOLT_SCALE, 32'(RST_VOLT_SCALE));
    add_write(REG_AMP_GAIN, 32'(RST_AMP_GAIN));
    add_write(REG_AMP_PLAIN, 32'(RST_AMP_PLAIN));
    add_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    add_write(REG_SPARE_HI, 32'h0000_0000);
    add_item(1023, 1023);
    add_item(0, 512);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk; register rows only once the meter has gone quiet
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        send_counts(directed_rows[i].volt_count, directed_rows[i].amp_count);
        predicted = predict_reading(directed_rows[i].volt_count, directed_rows[i].amp_count);
        pending_readings.push_back(directed_rows[i].kind == ROW_PINNED ?
                                   directed_rows[i].pinned : predicted);
        if ($urandom_range(0, 1) == 1) begin
          meas_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    // Random phases, each under a fresh register setting
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_results();
      flavour = $urandom_range(0, 4);
      case (flavour)
        0: begin  // reset values
          up_w = 32'(RST_RANGE_UP);   down_w = 32'(RST_RANGE_DOWN);
          press_w = 32'(RST_PRESS_LVL);
          vs_w = 32'(RST_VOLT_SCALE); ag_w = 32'(RST_AMP_GAIN);
          ap_w = 32'(RST_AMP_PLAIN);
        end
        1: begin  // 1 mV per count, so readings can land exactly on the press level
          up_w = $urandom_range(0, 1023);   down_w = $urandom_range(0, 1023);
          press_w = $urandom_range(0, 1100); vs_w = 32'd65536;
          ag_w = $urandom_range(0, 200000); ap_w = $urandom_range(0, 2000000);
        end
        2: begin  // raw words, upper bits must be dropped
          up_w = $urandom; down_w = $urandom; press_w = $urandom;
          vs_w = $urandom; ag_w = $urandom;   ap_w = $urandom;
        end
        3: begin  // each register at one end or the other
          up_w    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          down_w  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          press_w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          vs_w    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          ag_w    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          ap_w    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        default: begin  // plausible calibration around the defaults
          up_w = $urandom_range(900, 1023);        down_w = $urandom_range(0, 100);
          press_w = $urandom_range(1000, 3000);    vs_w = $urandom_range(300000, 500000);
          ag_w = $urandom_range(20000, 50000);     ap_w = $urandom_range(400000, 1000000);
        end
      endcase
      write_register(REG_RANGE_UP, up_w);
      write_register(REG_RANGE_DOWN, down_w);
      write_register(REG_PRESS_LVL, press_w);
      write_register(REG_VOLT_SCALE, vs_w);
      write_register(REG_AMP_GAIN, ag_w);
      write_register(REG_AMP_PLAIN, ap_w);
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);

      phase_left = $urandom_range(120, 280);
      while (phase_left > 0 && random_sent < RANDOM_ITEMS) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (int b = 0; b < burst && phase_left > 0; b++) begin
          // Uniform counts in four draws of ten, the rest steered at the range thresholds,
          // the press level, the rails and the bottom of the scale
          case ($urandom_range(0, 9))
            4, 5: begin
              aim = gain_mode_q ? longint'(meter_cfg.range_up_count)
                                : longint'(meter_cfg.range_down_count);
              ac = clamp_count(aim + int'($urandom_range(0, 4)) - 2);
              vc = COUNT_BITS'($urandom_range(0, COUNT_MAX));
            end
            6, 7: begin
              if (meter_cfg.volt_scale_q16 != 0)
                aim = (longint'(meter_cfg.press_level_mv) << FRAC_W) /
                      longint'(meter_cfg.volt_scale_q16);
              else
                aim = longint'($urandom_range(0, COUNT_MAX));
              vc = clamp_count(aim + int'($urandom_range(0, 4)) - 2);
              ac = COUNT_BITS'($urandom_range(0, COUNT_MAX));
            end
            8: begin
              vc = $urandom_range(0, 1) ? COUNT_MAX[COUNT_BITS-1:0] : '0;
              ac = $urandom_range(0, 1) ? COUNT_MAX[COUNT_BITS-1:0] : '0;
            end
            9: begin
              vc = COUNT_BITS'($urandom_range(0, 63));
              ac = COUNT_BITS'($urandom_range(0, 63));
            end
            default: begin
              vc = COUNT_BITS'($urandom_range(0, COUNT_MAX));
              ac = COUNT_BITS'($urandom_range(0, COUNT_MAX));
            end
          endcase
          send_counts(vc, ac);
          pending_readings.push_back(predict_reading(vc, ac));
          random_sent++;
          phase_left--;
        end
        case ($urandom_range(0, 5))
          0, 1:    gap = 0;
          5:       gap = $urandom_range(20, 60);
          default: gap = $urandom_range(1, 8);
        endcase
        if (gap > 0) begin
          meas_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
